/* sv/quaternion_to_euler_heading_assert.svh */
// assertion macros for the quaternion to euler heading block
`ifndef QUATERNION_TO_EULER_HEADING_ASSERT_SVH
`define QUATERNION_TO_EULER_HEADING_ASSERT_SVH
`ifndef SYNTHESIS
`define QEH_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define QEH_ASSERT_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define QEH_ASSERT(label, clk, rst_n, prop, msg)
`define QEH_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

/* sv/qeh_pkg.sv */
// package for the quaternion to euler heading block
package qeh_pkg;
    localparam int QUAT_FRAC_BITS_DEF = 14;
    localparam int CORDIC_STAGES_DEF  = 16;
    localparam int QW      = 16;
    localparam int CW      = 56;
    localparam int ZW      = 34;
    localparam int SQW     = 61;
    localparam int SQ_STEPS = 31;
    localparam logic [15:0] DECL_RESET = 16'sd280;
    localparam logic [1:0] ADDR_DECL = 2'd0;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 zero;
    } cvec_t;

    function automatic logic [31:0] atan_entry(input int i);
        logic [31:0] t [32];
        t = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
              32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
              32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
              32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
              32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
              32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
              32'h00000001, 32'h00000000};
        return t[i];
    endfunction
endpackage

/* sv/qeh_cordic_cell.sv */
// one vectoring cordic stage
module qeh_cordic_cell
    import qeh_pkg::*;
#(
    parameter int SHIFT = 0
)
(
    input  logic  clk,
    input  logic  en,
    input  cvec_t din,
    output cvec_t dout
);
    cvec_t nxt;
    always_comb
    begin
        nxt = din;
        if (din.y >= 0)
        begin
            nxt.x = din.x + (din.y >>> SHIFT);
            nxt.y = din.y - (din.x >>> SHIFT);
            nxt.z = din.z + ZW'(atan_entry(SHIFT));
        end
        else
        begin
            nxt.x = din.x - (din.y >>> SHIFT);
            nxt.y = din.y + (din.x >>> SHIFT);
            nxt.z = din.z - ZW'(atan_entry(SHIFT));
        end
    end
    always_ff @(posedge clk)
    begin
        if (en)
            dout <= nxt;
    end
endmodule

/* sv/qeh_sqrt_cell.sv */
// one step of the bit-serial integer square root
module qeh_sqrt_cell
    import qeh_pkg::*;
#(
    parameter int STEP = 0
)
(
    input  logic           clk,
    input  logic           en,
    input  logic [SQW-1:0] rem_in,
    input  logic [SQW-1:0] res_in,
    output logic [SQW-1:0] rem_out,
    output logic [SQW-1:0] res_out
);
    localparam logic [SQW-1:0] BIT = SQW'(1) << (60 - 2 * STEP);
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (rem_in >= res_in + BIT)
            begin
                rem_out <= rem_in - (res_in + BIT);
                res_out <= (res_in >> 1) + BIT;
            end
            else
            begin
                rem_out <= rem_in;
                res_out <= res_in >> 1;
            end
        end
    end
endmodule

/* sv/qeh_atan2.sv */
// atan2 as a row of cordic cells, result in hundredths of a degree
module qeh_atan2
    import qeh_pkg::*;
#(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
)
(
    input  logic                 clk,
    input  logic                 en,
    input  logic signed [35:0]   y,
    input  logic signed [35:0]   x,
    output logic signed [17:0]   angle
);
    localparam int NS = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
    cvec_t pre;
    cvec_t chain [NS+1];
    logic signed [ZW+17:0] prod_reg;
    logic signed [ZW+17:0] rnd;

    always_comb
    begin
        pre.zero = (x == 0) && (y == 0);
        pre.z = '0;
        pre.x = CW'(x) <<< 16;
        pre.y = CW'(y) <<< 16;
        if (x < 0)
        begin
            pre.z = (y >= 0) ? (ZW'(1) <<< 31) : -(ZW'(1) <<< 31);
            pre.x = -(CW'(x) <<< 16);
            pre.y = -(CW'(y) <<< 16);
        end
    end
    always_ff @(posedge clk)
    begin
        if (en)
            chain[0] <= pre;
    end
    for (genvar g = 0; g < NS; g++)
    begin : g_cell
        qeh_cordic_cell #(.SHIFT(g)) u_cell (.clk(clk), .en(en), .din(chain[g]),
            .dout(chain[g+1]));
    end
    always_ff @(posedge clk)
    begin
        if (en)
            prod_reg <= chain[NS].zero ? '0 : (ZW+18)'(chain[NS].z) * (ZW+18)'(36000);
    end
    always_comb
    begin
        rnd = prod_reg + ((ZW+18)'(1) <<< 31);
        angle = 18'(rnd >>> 32);
    end
endmodule

/* sv/quaternion_to_euler_heading.sv */
// top level: quaternion to euler angles and true heading
// stream in on s_axis (tdata = quat_real, quat_i, quat_j, quat_k from bit 0 up,
// 16 bits each); stream out on m_axis (tdata = yaw_angle[15:0],
// pitch_angle[30:16], roll_angle[46:31], true_heading[62:47], zero pad [63]).
// apb port: one register at address 0, declination, signed hundredths of a degree.
// one item is taken every cycle while the skid register is empty; each item runs
// through a pipeline of products, a 31 step square root row and a cordic row
// before it reaches the m_axis output register.
// a valid bit travels alongside every stage; when the receiver stalls, the
// skid register catches the item in flight and the whole pipeline holds while
// that register is full, so s_axis_tready depends only on registers.
// reset clears the valid bits and sets the declination to 2.80 degrees;
// no clearing pass is needed.
module quaternion_to_euler_heading
#(
    parameter int QUAT_FRAC_BITS = qeh_pkg::QUAT_FRAC_BITS_DEF,
    parameter int CORDIC_STAGES  = qeh_pkg::CORDIC_STAGES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // quat_real, quat_i, quat_j, quat_k
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // yaw, pitch, roll, true_heading, pad
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import qeh_pkg::*;
    `include "quaternion_to_euler_heading_assert.svh"

    localparam int NS  = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
    localparam int LAT = 2 + SQ_STEPS + 1 + NS + 2;
    localparam int SH  = 2 * QUAT_FRAC_BITS - 30;

    logic signed [15:0] decl_reg;
    logic [LAT-1:0] vld_reg;
    logic [63:0] out_reg, skid_reg;
    logic out_vld_reg, skid_vld_reg;
    logic adv;

    assign pready = 1'b1;
    assign prdata = (paddr[2:1] == ADDR_DECL) ? {{16{decl_reg[15]}}, decl_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            decl_reg <= DECL_RESET;
        else if (psel && penable && pwrite && (paddr[2:1] == ADDR_DECL))
            decl_reg <= pwdata[15:0];
    end

    // pipeline holds while the skid register is full
    assign adv = !skid_vld_reg;
    assign s_axis_tready = adv;

    // stage 1: products
    logic signed [15:0] w, x, y, z;
    assign w = s_axis_tdata[15:0];
    assign x = s_axis_tdata[31:16];
    assign y = s_axis_tdata[47:32];
    assign z = s_axis_tdata[63:48];
    logic signed [31:0] ww_reg, xx_reg, yy_reg, zz_reg, xy_reg, wz_reg, wx_reg, yz_reg;
    logic signed [31:0] wy_reg, xz_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ww_reg <= w * w; xx_reg <= x * x; yy_reg <= y * y; zz_reg <= z * z;
            xy_reg <= x * y; wz_reg <= w * z; wx_reg <= w * x; yz_reg <= y * z;
            wy_reg <= w * y; xz_reg <= x * z;
        end
    end

    // stage 2: sums and pitch argument
    logic signed [35:0] yy_s_reg, yx_s_reg, ry_s_reg, rx_s_reg;
    logic signed [35:0] a_c;
    logic signed [35:0] a30_c;
    logic signed [35:0] a30_reg;
    logic [SQW-1:0] sq_in;
    logic signed [61:0] one_c;
    assign one_c = 62'sd1 <<< (2 * QUAT_FRAC_BITS);
    always_comb
    begin
        a_c = 36'(2 * (36'(wy_reg) - 36'(xz_reg)));
        if (62'(a_c) > one_c) a_c = 36'(one_c);
        if (62'(a_c) < -one_c) a_c = -36'(one_c);
        if (SH > 0)
            a30_c = (a_c + (36'sd1 <<< ((SH > 0) ? SH - 1 : 0))) >>> ((SH > 0) ? SH : 0);
        else
            a30_c = a_c <<< ((SH > 0) ? 0 : -SH);
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            yy_s_reg <= 36'(2 * (36'(xy_reg) + 36'(wz_reg)));
            yx_s_reg <= 36'(ww_reg) + 36'(xx_reg) - 36'(yy_reg) - 36'(zz_reg);
            ry_s_reg <= 36'(2 * (36'(wx_reg) + 36'(yz_reg)));
            rx_s_reg <= 36'(ww_reg) - 36'(xx_reg) - 36'(yy_reg) + 36'(zz_reg);
            a30_reg  <= a30_c;
        end
    end
    logic [SQW-1:0] a_sq_reg;
    logic signed [35:0] a30_d_reg;
    logic signed [31:0] a30_n;
    logic signed [63:0] a_sq_c;
    assign a30_n  = 32'(a30_reg);
    assign a_sq_c = a30_n * a30_n;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_sq_reg  <= SQW'(a_sq_c);
            a30_d_reg <= a30_reg;
        end
    end
    assign sq_in = (SQW'(1) << 60) - a_sq_reg;

    // square root row with angle argument alongside
    logic [SQW-1:0] rem [SQ_STEPS+1];
    logic [SQW-1:0] res [SQ_STEPS+1];
    logic signed [35:0] ad [SQ_STEPS+1];
    assign rem[0] = sq_in;
    assign res[0] = '0;
    assign ad[0]  = a30_d_reg;
    for (genvar g = 0; g < SQ_STEPS; g++)
    begin : g_sq
        qeh_sqrt_cell #(.STEP(g)) u_sq (.clk(clk), .en(adv), .rem_in(rem[g]),
            .res_in(res[g]), .rem_out(rem[g+1]), .res_out(res[g+1]));
        always_ff @(posedge clk)
        begin
            if (adv)
                ad[g+1] <= ad[g];
        end
    end

    // delay yaw and roll to meet pitch
    localparam int DL = SQ_STEPS + 1;
    logic signed [35:0] dyy [DL+1];
    logic signed [35:0] dyx [DL+1];
    logic signed [35:0] dry [DL+1];
    logic signed [35:0] drx [DL+1];
    assign dyy[0] = yy_s_reg;
    assign dyx[0] = yx_s_reg;
    assign dry[0] = ry_s_reg;
    assign drx[0] = rx_s_reg;
    for (genvar g = 0; g < DL; g++)
    begin : g_dl
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dyy[g+1] <= dyy[g]; dyx[g+1] <= dyx[g];
                dry[g+1] <= dry[g]; drx[g+1] <= drx[g];
            end
        end
    end

    logic signed [17:0] yaw_a, roll_a, pitch_a;
    qeh_atan2 #(.CORDIC_STAGES(CORDIC_STAGES)) u_yaw (.clk(clk), .en(adv), .y(dyy[DL]),
        .x(dyx[DL]), .angle(yaw_a));
    qeh_atan2 #(.CORDIC_STAGES(CORDIC_STAGES)) u_roll (.clk(clk), .en(adv), .y(dry[DL]),
        .x(drx[DL]), .angle(roll_a));
    qeh_atan2 #(.CORDIC_STAGES(CORDIC_STAGES)) u_pitch (.clk(clk), .en(adv), .y(ad[SQ_STEPS]),
        .x(36'(res[SQ_STEPS])), .angle(pitch_a));

    // final clamps and heading
    logic signed [17:0] yaw_c, roll_c, pitch_c, decl_c, head_c;
    logic [63:0] res_c;
    always_comb
    begin
        yaw_c = (yaw_a > 18'sd18000) ? 18'sd18000 : ((yaw_a < -18'sd18000) ? -18'sd18000 : yaw_a);
        roll_c = (roll_a > 18'sd18000) ? 18'sd18000 :
                 ((roll_a < -18'sd18000) ? -18'sd18000 : roll_a);
        pitch_c = (pitch_a > 18'sd9000) ? 18'sd9000 :
                  ((pitch_a < -18'sd9000) ? -18'sd9000 : pitch_a);
        decl_c = 18'(decl_reg);
        if (decl_c > 18'sd18000) decl_c = 18'sd18000;
        if (decl_c < -18'sd18000) decl_c = -18'sd18000;
        head_c = yaw_c + decl_c;
        if (head_c >= 18'sd36000) head_c = head_c - 18'sd36000;
        if (head_c < 0) head_c = head_c + 18'sd36000;
        res_c = {1'b0, head_c[15:0], roll_c[15:0], pitch_c[14:0], yaw_c[15:0]};
    end

    // valid line, output register and skid
    logic in_acc, out_acc, vin;
    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;
    assign vin = vld_reg[LAT-1];
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            out_vld_reg <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else
        begin
            if (adv)
                vld_reg <= {vld_reg[LAT-2:0], in_acc};
            if (!out_vld_reg || out_acc)
            begin
                out_vld_reg <= skid_vld_reg || vin;
                skid_vld_reg <= 1'b0;
            end
            else if (adv)
            begin
                skid_vld_reg <= vin;
            end
        end
    end
    always_ff @(posedge clk)
    begin
        if (!out_vld_reg || out_acc)
            out_reg <= skid_vld_reg ? skid_reg : res_c;
        else if (adv)
            skid_reg <= res_c;
    end
    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_reg;

    `QEH_ASSERT(a_pready, clk, rst_n, pready, "pready low")
    `QEH_ASSERT(a_hold, clk, rst_n, (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid,
        "result dropped")
    `QEH_ASSERT(a_heading, clk, rst_n, m_axis_tvalid |-> (m_axis_tdata[62:47] < 16'd36000),
        "heading out of range")
endmodule
